[design/iraf_pkg.sv]
package iraf_pkg;

    typedef enum logic [1:0] {
        MODE_OCT = 2'd0,
        MODE_DEC = 2'd1,
        MODE_HEX = 2'd2,
        MODE_BAD = 2'd3
    } mode_t;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;   // '0'
    localparam logic [7:0]  CHAR_A_OFS = 8'h37;   // 'A' - 10
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;   // '-'
    localparam logic [7:0]  CHAR_STAR  = 8'h2A;   // '*'
    localparam logic [7:0]  CHAR_SPACE = 8'h20;   // ' '
    localparam logic [6:0]  STAR_COUNT = 7'd4;
    localparam logic [6:0]  PAD_SAT    = 7'd127;

    // decimal long division: one 16-bit slice per step, remainder carried in
    localparam int          DEC_SLICE  = 16;
    localparam logic [19:0] DEC_RADIX  = 20'd10;
    localparam logic [19:0] DEC_RECIP  = 20'd838861; // ceil(2^23 / 10), exact below 10 * 2^16
    localparam int          DEC_SHIFT  = 23;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d <= 4'd9)
        begin
            c = CHAR_ZERO + {4'b0, d};
        end
        else
        begin
            c = CHAR_A_OFS + {4'b0, d};
        end
        return c;
    endfunction

endpackage

[design/iraf_div.sv]
// One divide-by-radix step: shift for octal and hex; for decimal, one 16-bit slice of
// long division by ten (reciprocal multiply), remainder of the slice above carried in.
module iraf_div
    import iraf_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int SLICE_W    = 2
) (
    input  logic [VALUE_BITS-1:0] dividend,
    input  mode_t                 mode,
    input  logic [SLICE_W-1:0]    slice,
    input  logic [3:0]            rem_in,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [3:0]            remainder
);

    localparam int SLICES = (VALUE_BITS + DEC_SLICE - 1) / DEC_SLICE;
    localparam int PW     = SLICES * DEC_SLICE;

    logic [PW-1:0] dec_in;
    logic [PW-1:0] dec_q;
    logic [19:0]   part;
    logic [39:0]   prod;
    logic [15:0]   part_q;
    logic [19:0]   part_r;

    // selected slice is replaced by its quotient; remainder always below ten
    always_comb
    begin
        dec_in = PW'(dividend);
        part   = {rem_in, dec_in[slice*DEC_SLICE +: DEC_SLICE]};
        prod   = {20'b0, part} * {20'b0, DEC_RECIP};
        part_q = prod[DEC_SHIFT +: DEC_SLICE];
        part_r = part - {4'b0, part_q} * DEC_RADIX;
        dec_q  = dec_in;
        dec_q[slice*DEC_SLICE +: DEC_SLICE] = part_q;
    end

    always_comb
    begin
        case (mode)
            MODE_OCT:
            begin
                quotient  = dividend >> 3;
                remainder = {1'b0, dividend[2:0]};
            end
            MODE_DEC:
            begin
                quotient  = dec_q[VALUE_BITS-1:0];
                remainder = part_r[3:0];
            end
            default:
            begin
                quotient  = dividend >> 4;
                remainder = dividend[3:0];
            end
        endcase
    end

endmodule

[design/integer_radix_ascii_formatter_top.sv]
// Integer to ASCII formatter. Each input transfer carries a value, a radix select, a signed
// flag, a field width, a justify flag and a fill byte; the block answers with a run-length
// list of characters, most significant first, one output transfer per run, with tlast on the
// final one. Hex digits are uppercase, a negative signed value gets a leading '-', and one run
// of fill bytes (fill 0 means space) pads the field before the characters, or after them when
// left-justified; a width above MAX_WIDTH means no padding. The invalid radix answers '*' x4.
// One shared divide-by-radix unit yields the digits, least significant first. Octal
// and hex yield one digit per cycle (a shift); decimal handles one 16-bit slice of the value
// per cycle, four slices per digit for 64-bit values (long division by ten). An item is
// accepted, then converted (up to 22 digits for octal, 20 for decimal, 16 for hex), then
// sent as output transfers (pad, sign, digits, pad), each of which waits while the
// consumer stalls; an invalid radix goes straight to its single output transfer.
// The input is not ready until the last transfer of the item has been loaded into the output
// register; that register lets the next item start while the final result still waits.
module integer_radix_ascii_formatter_top
    import iraf_pkg::*;
#(
    parameter int MAX_WIDTH  = 80,
    parameter int VALUE_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // value[63:0], field_width[71:64], left_justify[72],
                                        // fill_byte[80:73], zeros above
    input  logic [2:0]  s_axis_tuser,   // mode[1:0], is_signed[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_char[7:0], repeat_count[14:8], zero[15]
    output logic        m_axis_tlast    // last_flag
);

    localparam int MAX_DIG = (VALUE_BITS + 2) / 3;
    localparam int DIG_W   = $clog2(MAX_DIG + 1);
    localparam int SLICES  = (VALUE_BITS + DEC_SLICE - 1) / DEC_SLICE;
    localparam int SLICE_W = (SLICES > 1) ? $clog2(SLICES) : 1;
    // only a 22-digit negative octal value with a pad can overflow the result list
    localparam bit MERGE_OK = (MAX_DIG == 22);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_CONV,
        S_PRE,
        S_SIGN,
        S_DIGS,
        S_POST
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   val_reg, val_next;
    mode_t                   mode_reg, mode_next;
    logic                    neg_reg, neg_next;
    logic                    left_reg, left_next;
    logic [7:0]              fill_reg, fill_next;
    logic [7:0]              weff_reg, weff_next;
    logic [6:0]              pad_reg, pad_next;
    logic [DIG_W-1:0]        nd_reg, nd_next;
    logic                    merge_reg, merge_next;
    logic [SLICE_W-1:0]      slice_reg, slice_next;
    logic [3:0]              rem_reg, rem_next;
    logic [3:0]              dig_reg [MAX_DIG];
    logic [3:0]              dig_next [MAX_DIG];
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_char_reg, out_char_next;
    logic [6:0]              out_cnt_reg, out_cnt_next;
    logic                    out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0]   in_val;
    logic [VALUE_BITS-1:0]   div_q;
    logic [3:0]              div_r;
    logic                    slot_free;
    logic [DIG_W-1:0]        nd_inc;
    logic                    digit_step;
    logic                    conv_done;
    logic [7:0]              n_chars;
    logic [7:0]              pad_wide;
    logic [6:0]              pad_calc;
    logic                    two_left;
    logic                    dig_final;

    iraf_div #(
        .VALUE_BITS (VALUE_BITS),
        .SLICE_W    (SLICE_W)
    ) u_div (
        .dividend  (val_reg),
        .mode      (mode_reg),
        .slice     (slice_reg),
        .rem_in    (rem_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

    assign in_val     = s_axis_tdata[VALUE_BITS-1:0];
    assign slot_free  = !out_valid_reg || m_axis_tready;
    assign nd_inc     = nd_reg + DIG_W'(1);
    // decimal finishes a digit on the lowest slice, octal and hex every cycle
    assign digit_step = (mode_reg != MODE_DEC) || (slice_reg == '0);
    assign conv_done  = (div_q == '0) || (nd_inc == DIG_W'(MAX_DIG));

    // characters including sign, then the pad run, saturated to the count field
    assign n_chars  = 8'(nd_inc) + {7'b0, neg_reg};
    assign pad_wide = (weff_reg > n_chars) ? (weff_reg - n_chars) : 8'd0;
    assign pad_calc = (pad_wide > {1'b0, PAD_SAT}) ? PAD_SAT : pad_wide[6:0];

    assign two_left  = merge_reg && (nd_reg == DIG_W'(2));
    assign dig_final = (nd_reg == DIG_W'(1)) || two_left;

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        mode_next      = mode_reg;
        neg_next       = neg_reg;
        left_next      = left_reg;
        fill_next      = fill_reg;
        weff_next      = weff_reg;
        pad_next       = pad_reg;
        nd_next        = nd_reg;
        merge_next     = merge_reg;
        slice_next     = slice_reg;
        rem_next       = rem_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = mode_t'(s_axis_tuser[1:0]);
                    neg_next   = s_axis_tuser[2] && in_val[VALUE_BITS-1];
                    val_next   = (s_axis_tuser[2] && in_val[VALUE_BITS-1]) ? (-in_val) : in_val;
                    weff_next  = ({1'b0, s_axis_tdata[71:64]} > 9'(MAX_WIDTH)) ?
                                 8'd0 : s_axis_tdata[71:64];
                    left_next  = s_axis_tdata[72];
                    fill_next  = (s_axis_tdata[80:73] == 8'd0) ? CHAR_SPACE : s_axis_tdata[80:73];
                    nd_next    = '0;
                    merge_next = 1'b0;
                    slice_next = SLICE_W'(SLICES - 1);
                    rem_next   = '0;
                    state_next = (mode_t'(s_axis_tuser[1:0]) == MODE_BAD) ? S_ERR : S_CONV;
                end
            end
            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_STAR;
                    out_cnt_next   = STAR_COUNT;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CONV:
            begin
                val_next = div_q;
                if (!digit_step)
                begin
                    // next lower slice of the decimal division
                    rem_next   = div_r;
                    slice_next = slice_reg - SLICE_W'(1);
                end
                else
                begin
                    rem_next   = '0;
                    slice_next = SLICE_W'(SLICES - 1);
                    // newest digit enters at the bottom, so the top digit ends at index 0
                    nd_next     = nd_inc;
                    dig_next[0] = div_r;
                    for (int i = 1; i < MAX_DIG; i++)
                    begin
                        dig_next[i] = dig_reg[i-1];
                    end
                    if (conv_done)
                    begin
                        pad_next   = pad_calc;
                        merge_next = MERGE_OK && neg_reg && (nd_inc == DIG_W'(MAX_DIG)) &&
                                     (pad_calc != 7'd0) &&
                                     (dig_next[MAX_DIG-2] == dig_next[MAX_DIG-1]);
                        if ((pad_calc != 7'd0) && !left_reg)
                        begin
                            state_next = S_PRE;
                        end
                        else
                        begin
                            state_next = neg_reg ? S_SIGN : S_DIGS;
                        end
                    end
                end
            end
            S_PRE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = fill_reg;
                    out_cnt_next   = pad_reg;
                    out_last_next  = 1'b0;
                    state_next     = neg_reg ? S_SIGN : S_DIGS;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_cnt_next   = 7'd1;
                    out_last_next  = 1'b0;
                    state_next     = S_DIGS;
                end
            end
            S_DIGS:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_char(dig_reg[0]);
                    out_cnt_next   = two_left ? 7'd2 : 7'd1;
                    out_last_next  = dig_final && !((pad_reg != 7'd0) && left_reg);
                    nd_next        = nd_reg - DIG_W'(1);
                    for (int i = 0; i < MAX_DIG - 1; i++)
                    begin
                        dig_next[i] = dig_reg[i+1];
                    end
                    if (dig_final)
                    begin
                        nd_next    = '0;
                        state_next = ((pad_reg != 7'd0) && left_reg) ? S_POST : S_IDLE;
                    end
                end
            end
            S_POST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = fill_reg;
                    out_cnt_next   = pad_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            merge_reg     <= 1'b0;
            slice_reg     <= '0;
            rem_reg       <= '0;
            val_reg       <= '0;
            mode_reg      <= MODE_OCT;
            neg_reg       <= 1'b0;
            left_reg      <= 1'b0;
            fill_reg      <= '0;
            weff_reg      <= '0;
            pad_reg       <= '0;
            dig_reg       <= '{default: 4'd0};
            out_char_reg  <= '0;
            out_cnt_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            merge_reg     <= merge_next;
            slice_reg     <= slice_next;
            rem_reg       <= rem_next;
            val_reg       <= val_next;
            mode_reg      <= mode_next;
            neg_reg       <= neg_next;
            left_reg      <= left_next;
            fill_reg      <= fill_next;
            weff_reg      <= weff_next;
            pad_reg       <= pad_next;
            dig_reg       <= dig_next;
            out_char_reg  <= out_char_next;
            out_cnt_reg   <= out_cnt_next;
            out_last_reg  <= out_last_next;
        end
    end

    // every run carries at least one character
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:8] != 7'd0))
        else $error("output run with zero repeat count");

    // a transfer on the input starts a multi-cycle item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // digit count stays within the digit store
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= DIG_W'(MAX_DIG))
        else $error("digit count beyond store depth");

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iraf_pkg::*;

    localparam int MAX_WIDTH  = 80;
    localparam int RUN_LIMIT  = 23;     // most runs one request may produce
    localparam int DIGIT_CAP  = 22;     // digit loop stops here (64-bit octal)
    localparam int CALM_TAIL  = 40;     // last requests go without idling

    // One request as it travels on the slave side.
    typedef struct packed {
        logic [63:0] value;
        mode_t       mode;
        logic        is_signed;
        logic [7:0]  field_width;
        logic        left_justify;
        logic [7:0]  fill_byte;
    } fmt_req_t;

    // One character run as it travels on the master side.
    typedef struct packed {
        logic [7:0] ch;
        logic [6:0] count;
        logic       last;
    } char_run_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    fmt_req_t  pending_reqs[$];     // requests not yet put on the bus
    char_run_t expected_runs[$];    // runs predicted but not yet seen
    fmt_req_t  req_on_bus;

    int mismatches   = 0;
    int runs_checked = 0;
    int reqs_sent    = 0;
    int mode_tally[4] = '{0, 0, 0, 0};
    int src_gap      = 0;
    int sink_stall   = 0;
    int src_odds     = 0;           // 0: no idling, n: one chance in 2<<n per cycle
    int sink_odds    = 0;
    int cyc          = 0;

    integer_radix_ascii_formatter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Works out the character runs for one request and queues them.
    function automatic void format_runs(input fmt_req_t r);
        logic [63:0] mag;
        logic [63:0] base;
        logic [7:0]  fill;
        logic [7:0]  digits_rev [0:23];
        logic [7:0]  run_ch [0:23];
        logic [6:0]  run_n [0:23];
        logic        neg;
        int          width;
        int          nchar;
        int          nrun;
        int          pad;
        int          d;
        char_run_t   runs[$];
        char_run_t   run;
        fill  = (r.fill_byte == 8'd0) ? CHAR_SPACE : r.fill_byte;
        width = (r.field_width > MAX_WIDTH) ? 0 : int'(r.field_width);
        if (r.mode == MODE_BAD)
        begin
            run.ch    = CHAR_STAR;
            run.count = STAR_COUNT;
            run.last  = 1'b1;
            expected_runs.push_back(run);
            return;
        end
        base = (r.mode == MODE_OCT) ? 64'd8 : (r.mode == MODE_DEC) ? 64'd10 : 64'd16;
        neg  = r.is_signed && r.value[63];
        mag  = neg ? (64'd0 - r.value) : r.value;

        // digits come out least significant first
        nchar = 0;
        do
        begin
            d = int'(mag % base);
            mag = mag / base;
            digits_rev[nchar] = (d <= 9) ? CHAR_ZERO + 8'(d) : CHAR_A_OFS + 8'(d);
            nchar++;
        end
        while (mag != 64'd0 && nchar < DIGIT_CAP);
        if (neg)
        begin
            digits_rev[nchar] = CHAR_MINUS;
            nchar++;
        end

        pad = (width > nchar) ? width - nchar : 0;
        if (pad > int'(PAD_SAT))
            pad = int'(PAD_SAT);

        nrun = 0;
        for (int i = nchar; i > 0; i--)
        begin
            run_ch[nrun] = digits_rev[i - 1];
            run_n[nrun]  = 7'd1;
            nrun++;
        end
        // Over the run budget: fold the two trailing equal digits into one run.
        if (nrun + ((pad != 0) ? 1 : 0) > RUN_LIMIT && nrun >= 2
            && run_ch[nrun - 1] == run_ch[nrun - 2])
        begin
            run_n[nrun - 2] = run_n[nrun - 2] + 7'd1;
            nrun--;
        end

        run.last = 1'b0;
        if (pad != 0 && !r.left_justify)
        begin
            run.ch    = fill;
            run.count = 7'(pad);
            runs.push_back(run);
        end
        for (int i = 0; i < nrun; i++)
        begin
            run.ch    = run_ch[i];
            run.count = run_n[i];
            runs.push_back(run);
        end
        if (pad != 0 && r.left_justify)
        begin
            run.ch    = fill;
            run.count = 7'(pad);
            runs.push_back(run);
        end
        runs[runs.size() - 1].last = 1'b1;
        foreach (runs[i])
            expected_runs.push_back(runs[i]);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s on run %0d: got %0h, expected %0h",
                 $realtime, what, runs_checked, got, want);
        mismatches++;
    endtask

    function automatic fmt_req_t make_req(input logic [63:0] value, input mode_t mode,
                                          input logic sgn, input logic [7:0] width,
                                          input logic left, input logic [7:0] fill);
        fmt_req_t r;
        r.value        = value;
        r.mode         = mode;
        r.is_signed    = sgn;
        r.field_width  = width;
        r.left_justify = left;
        r.fill_byte    = fill;
        return r;
    endfunction

    function automatic fmt_req_t random_req();
        fmt_req_t    r;
        logic [63:0] small_val;
        small_val = 64'($urandom_range(0, 1000));
        case ($urandom_range(0, 6))
            0:       r.value = small_val;
            1:       r.value = 64'd0 - small_val;
            2:       r.value = 64'd1 << $urandom_range(0, 63);
            3:       r.value = {{32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            4:       r.value = ($urandom_range(0, 1) == 1) ? '1 : 64'h8000_0000_0000_0000;
            default: r.value = {32'($urandom), 32'($urandom)};
        endcase
        r.mode = ($urandom_range(0, 15) == 0) ? MODE_BAD : mode_t'($urandom_range(0, 2));
        r.is_signed = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       r.field_width = 8'($urandom_range(0, 255));
            1, 2:    r.field_width = 8'd0;
            default: r.field_width = 8'($urandom_range(1, 30));
        endcase
        r.left_justify = 1'($urandom_range(0, 1));
        r.fill_byte = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Idle density changes every so often, so busy stretches alternate with
    // stretches where one side or both never pause.
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 97 == 0)
        begin
            src_odds  <= $urandom_range(0, 3);
            sink_odds <= $urandom_range(0, 3);
        end
    end

    // Driver: predicts each request on its accepting edge, then offers the next.
    always @(posedge clk)
    begin : driver
        logic drive_valid;
        if (rst_n)
        begin
            drive_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                format_runs(req_on_bus);
                mode_tally[req_on_bus.mode]++;
                reqs_sent++;
                drive_valid = 1'b0;
            end
            if (!drive_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_reqs.size() >= CALM_TAIL && src_odds != 0
                         && $urandom_range(0, (2 << src_odds) - 1) == 0)
                    src_gap = $urandom_range(1, 19) - 1;
                else if (pending_reqs.size() > 0)
                begin
                    req_on_bus = pending_reqs.pop_front();
                    s_axis_tdata <= {7'b0, req_on_bus.fill_byte, req_on_bus.left_justify,
                                     req_on_bus.field_width, req_on_bus.value};
                    s_axis_tuser <= {req_on_bus.is_signed, req_on_bus.mode};
                    drive_valid = 1'b1;
                end
            end
            s_axis_tvalid <= drive_valid;
        end
    end

    // Sink side backpressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (pending_reqs.size() >= CALM_TAIL && sink_odds != 0
                     && $urandom_range(0, (2 << sink_odds) - 1) == 0)
            begin
                sink_stall = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: each output transfer against the oldest predicted run.
    always @(posedge clk)
    begin : monitor
        char_run_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_runs.size() == 0)
                report_mismatch("unexpected transfer", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = expected_runs.pop_front();
                if (m_axis_tdata[7:0] != want.ch)
                    report_mismatch("out_char", 64'(m_axis_tdata[7:0]), 64'(want.ch));
                if (m_axis_tdata[14:8] != want.count)
                    report_mismatch("repeat_count", 64'(m_axis_tdata[14:8]), 64'(want.count));
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
                runs_checked++;
            end
        end
    end

    initial
    begin
        // zero, full-scale and most-negative values in every radix
        pending_reqs.push_back(make_req(64'd0, MODE_OCT, 1'b0, 8'd0, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'd0, MODE_DEC, 1'b1, 8'd1, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'd0, MODE_HEX, 1'b0, 8'd5, 1'b1, 8'h2E));
        pending_reqs.push_back(make_req('1, MODE_OCT, 1'b0, 8'd0, 1'b0, 8'd0));
        pending_reqs.push_back(make_req('1, MODE_DEC, 1'b0, 8'd20, 1'b0, 8'd0));
        pending_reqs.push_back(make_req('1, MODE_HEX, 1'b0, 8'd17, 1'b1, 8'hFF));
        pending_reqs.push_back(make_req('1, MODE_DEC, 1'b1, 8'd4, 1'b0, 8'h30));
        // most negative in octal: with a pad, 24 runs folded into 23; without one, no fold
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_OCT, 1'b1,
                                        8'd30, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_OCT, 1'b1,
                                        8'd30, 1'b1, 8'h30));
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_OCT, 1'b1,
                                        8'd23, 1'b0, 8'h30));
        // zero fill on a negative value: pad lands ahead of the sign
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_DEC, 1'b1,
                                        8'd80, 1'b0, 8'h30));
        pending_reqs.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, MODE_DEC, 1'b1,
                                        8'd25, 1'b1, 8'h2A));
        pending_reqs.push_back(make_req(64'h0123_4567_89AB_CDEF, MODE_HEX, 1'b0,
                                        8'd16, 1'b0, 8'd0));
        // widths above the limit mean no pad; a width at the limit still pads
        pending_reqs.push_back(make_req(64'hFEDC_BA98_7654_3210, MODE_HEX, 1'b1,
                                        8'd81, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'd12345, MODE_DEC, 1'b0, 8'd255, 1'b0, 8'hFF));
        pending_reqs.push_back(make_req(64'd7, MODE_OCT, 1'b0, 8'd80, 1'b1, 8'h01));
        // invalid radix ignores everything else
        pending_reqs.push_back(make_req(64'hA5A5_5A5A_F00F_0FF0, MODE_BAD, 1'b1,
                                        8'd40, 1'b1, 8'h30));
        pending_reqs.push_back(make_req(64'd0, MODE_BAD, 1'b0, 8'd0, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'd9, MODE_DEC, 1'b1, 8'd1, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'hFFFF_FFFF_FFFF_FFF6, MODE_HEX, 1'b1,
                                        8'd3, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'd8, MODE_OCT, 1'b0, 8'd2, 1'b0, 8'd0));
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_HEX, 1'b1,
                                        8'd20, 1'b1, 8'h80));
        pending_reqs.push_back(make_req(64'h8000_0000_0000_0000, MODE_DEC, 1'b0,
                                        8'd80, 1'b0, 8'd0));
        repeat (387)
            pending_reqs.push_back(random_req());

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_runs.size() != 0)
            @(posedge clk);
        // let any stray transfer show up
        repeat (64) @(posedge clk);

        $display("Formatted %0d requests: %0d octal, %0d decimal, %0d hex, %0d bad radix.",
                 reqs_sent, mode_tally[MODE_OCT], mode_tally[MODE_DEC],
                 mode_tally[MODE_HEX], mode_tally[MODE_BAD]);
        $display("Checked %0d character runs, %0d mismatches.", runs_checked, mismatches);
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("integer_radix_ascii_formatter_top test passed");
        else
            $display("integer_radix_ascii_formatter_top test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timed out with %0d requests queued and %0d runs outstanding.",
                 pending_reqs.size(), expected_runs.size());
        $display("integer_radix_ascii_formatter_top test failed");
        $finish;
    end

endmodule
